// ===== hdl/signed_radix_digit_emitter_core_defines.svh =====
// assertion macros shared by the rtl files
`ifndef SIGNED_RADIX_DIGIT_EMITTER_CORE_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define SRDE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define SRDE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SRDE_ASSERT(lbl, prop, msg)
`define SRDE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/srde_pkg.sv =====
package srde_pkg;

   localparam int VALUE_W        = 32;
   localparam int SYM_W          = 8;
   localparam int RADIX_W        = 5;
   localparam int MAX_RADIX      = 16;
   localparam int DIGIT_W        = $clog2(MAX_RADIX);
   localparam int MAX_DIGITS     = VALUE_W;
   localparam int COUNT_W        = $clog2(MAX_DIGITS + 1);
   localparam int BITS_PER_CYCLE = 4;
   localparam int STEPS_PER_DIG  = VALUE_W / BITS_PER_CYCLE;
   localparam int STEP_W         = $clog2(STEPS_PER_DIG);
   localparam int SYM_SLOTS      = 16;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 64;

   localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_HIGH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_EMIT
   } srde_state_type;

   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] dividend;
   } srde_div_ctrl_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
      logic [DIGIT_W-1:0] digit;
   } srde_div_stat_type;

endpackage

// ===== hdl/srde_alphabet.sv =====
module srde_alphabet (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [srde_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srde_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [srde_pkg::DIGIT_W-1:0]         digit,
   output logic [srde_pkg::SYM_W-1:0]           symbol,
   output logic [srde_pkg::RADIX_W-1:0]         radix,
   output logic                                 alphabet_ok
);

   logic [srde_pkg::RADIX_W-1:0]    radix_ff, radix_in;
   logic [srde_pkg::CSR_DATA_W-1:0] sym_low_ff, sym_low_in;
   logic [srde_pkg::CSR_DATA_W-1:0] sym_high_ff, sym_high_in;
   logic                            ok_ff, ok_in;
   logic [2*srde_pkg::CSR_DATA_W-1:0] sym_all;
   logic [srde_pkg::SYM_W-1:0]      sym [srde_pkg::SYM_SLOTS];
   logic                            wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      radix_in    = radix_ff;
      sym_low_in  = sym_low_ff;
      sym_high_in = sym_high_ff;
      if (wr) begin
         unique case (csr_index)
            srde_pkg::CSR_RADIX:    radix_in    = csr_data[srde_pkg::RADIX_W-1:0];
            srde_pkg::CSR_SYM_LOW:  sym_low_in  = csr_data;
            srde_pkg::CSR_SYM_HIGH: sym_high_in = csr_data;
            default: ;
         endcase
      end
   end

   assign sym_all = {sym_high_ff, sym_low_ff};

   always_comb begin
      for (int i = 0; i < srde_pkg::SYM_SLOTS; i++) begin
         sym[i] = sym_all[i*srde_pkg::SYM_W +: srde_pkg::SYM_W];
      end
   end

   // radix in range, and no forbidden or repeated symbols among the slots in use
   always_comb begin
      ok_in = (radix_ff >= srde_pkg::RADIX_W'(2))
           && (radix_ff <= srde_pkg::RADIX_W'(srde_pkg::MAX_RADIX));
      for (int i = 0; i < srde_pkg::MAX_RADIX; i++) begin
         if (srde_pkg::RADIX_W'(i) < radix_ff) begin
            if (sym[i] == '0 || sym[i] == srde_pkg::SIGN_PLUS
                || sym[i] == srde_pkg::SIGN_MINUS) begin
               ok_in = 1'b0;
            end
            for (int j = i + 1; j < srde_pkg::MAX_RADIX; j++) begin
               if (srde_pkg::RADIX_W'(j) < radix_ff && sym[j] == sym[i]) begin
                  ok_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= '0;
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
         ok_ff       <= 1'b0;
      end else begin
         radix_ff    <= radix_in;
         sym_low_ff  <= sym_low_in;
         sym_high_ff <= sym_high_in;
         ok_ff       <= ok_in;
      end
   end

   assign symbol      = sym[digit];
   assign radix       = radix_ff;
   assign alphabet_ok = ok_ff;

endmodule

// ===== hdl/srde_div_unit.sv =====
`include "signed_radix_digit_emitter_core_defines.svh"

module srde_div_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  srde_pkg::srde_div_ctrl_type   ctrl,
   input  logic [srde_pkg::RADIX_W-1:0]  radix,
   output srde_pkg::srde_div_stat_type   stat
);

   logic                          busy_ff, busy_in;
   logic [srde_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [srde_pkg::VALUE_W-1:0]  dvd_ff, dvd_in, dvd_nx;
   logic [srde_pkg::DIGIT_W-1:0]  rem_ff, rem_in, rem_nx;
   logic                          last_step;

   // restoring division, a few quotient bits per cycle
   always_comb begin
      logic [srde_pkg::DIGIT_W:0] part;
      logic                       ge;
      dvd_nx = dvd_ff;
      rem_nx = rem_ff;
      for (int b = 0; b < srde_pkg::BITS_PER_CYCLE; b++) begin
         part = {rem_nx, dvd_nx[srde_pkg::VALUE_W-1]};
         ge   = (part >= radix);
         if (ge) begin
            part = part - radix;
         end
         rem_nx = part[srde_pkg::DIGIT_W-1:0];
         dvd_nx = {dvd_nx[srde_pkg::VALUE_W-2:0], ge};
      end
   end

   assign last_step = (step_ff == srde_pkg::STEP_W'(srde_pkg::STEPS_PER_DIG - 1));

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = ctrl.dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff + srde_pkg::STEP_W'(1);
         dvd_in  = dvd_nx;
         rem_in  = rem_nx;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign stat.done     = busy_ff && last_step;
   assign stat.quotient = dvd_nx;
   assign stat.digit    = rem_nx;

   `SRDE_ASSERT(a_rem_below_radix, busy_ff |-> ({1'b0, rem_ff} < radix), "remainder not below radix")

endmodule

// ===== hdl/signed_radix_digit_emitter_core.sv =====
// channel | ports  | direction | payload
// request | req_*  | in        | tdata[31:0] value (signed)
// symbol  | rsp_*  | out       | tdata[7:0] symbol, tlast last
// config  | csr_*  | in        | index[1:0] register, data[63:0]
//
// a value is divided into its digits one after another by the shared divider, which produces
// 4 quotient bits a cycle; the digits are then emitted, a minus sign first if the value is negative
// a value is dropped without symbols if the alphabet is rejected; longest output is radix 2 with -2^31
// reset clears the sequencer and its control registers, not the data registers; no clearing pass
// a stalled symbol output holds only the emit phase; req_tready is high while idle

`include "signed_radix_digit_emitter_core_defines.svh"

module signed_radix_digit_emitter_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic signed [srde_pkg::VALUE_W-1:0]    req_tdata,   // [31:0] value
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [srde_pkg::SYM_W-1:0]             rsp_tdata,   // [7:0] symbol
   output logic                                   rsp_tlast,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [srde_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [srde_pkg::CSR_DATA_W-1:0]        csr_data
);

   srde_pkg::srde_state_type      state_ff, state_in;
   logic [srde_pkg::VALUE_W-1:0]  mag_ff, mag_in;
   logic                          sign_pend_ff, sign_pend_in;
   logic [srde_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [srde_pkg::DIGIT_W-1:0]  digits_ff [srde_pkg::MAX_DIGITS];
   logic [srde_pkg::DIGIT_W-1:0]  digits_in [srde_pkg::MAX_DIGITS];
   logic                          out_valid_ff, out_valid_in;
   logic [srde_pkg::SYM_W-1:0]    out_sym_ff, out_sym_in;
   logic                          out_last_ff, out_last_in;

   logic [srde_pkg::VALUE_W-1:0]  raw;
   logic                          accept, out_free, out_load, push, pop, final_digit;
   logic [srde_pkg::SYM_W-1:0]    digit_sym;
   logic [srde_pkg::RADIX_W-1:0]  radix;
   logic                          alphabet_ok;
   srde_pkg::srde_div_ctrl_type   div_ctrl;
   srde_pkg::srde_div_stat_type   div_stat;

   srde_alphabet u_alphabet (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .digit       (digits_ff[0]),
      .symbol      (digit_sym),
      .radix       (radix),
      .alphabet_ok (alphabet_ok)
   );

   srde_div_unit u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .radix (radix),
      .stat  (div_stat)
   );

   assign raw         = req_tdata;
   assign accept      = req_tvalid && req_tready;
   assign out_free    = !out_valid_ff || rsp_tready;
   assign final_digit = (div_stat.quotient == '0)
                     || (count_ff == srde_pkg::COUNT_W'(srde_pkg::MAX_DIGITS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srde_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = srde_pkg::ST_CHECK;
         end
         srde_pkg::ST_CHECK: begin
            state_in = alphabet_ok ? srde_pkg::ST_DIVIDE : srde_pkg::ST_IDLE;
         end
         srde_pkg::ST_DIVIDE: begin
            if (div_stat.done && final_digit) state_in = srde_pkg::ST_EMIT;
         end
         srde_pkg::ST_EMIT: begin
            if (out_free && !sign_pend_ff && count_ff == srde_pkg::COUNT_W'(1)) begin
               state_in = srde_pkg::ST_IDLE;
            end
         end
         default: state_in = srde_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready        = 1'b0;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = div_stat.quotient;
      push              = 1'b0;
      out_load          = 1'b0;
      unique case (state_ff)
         srde_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         srde_pkg::ST_CHECK: begin
            div_ctrl.start    = alphabet_ok;
            div_ctrl.dividend = mag_ff;
         end
         srde_pkg::ST_DIVIDE: begin
            push           = div_stat.done;
            div_ctrl.start = div_stat.done && !final_digit;
         end
         srde_pkg::ST_EMIT: begin
            out_load = out_free;
         end
         default: ;
      endcase
   end

   assign pop = out_load && !sign_pend_ff;

   always_comb begin
      mag_in       = mag_ff;
      sign_pend_in = sign_pend_ff;
      count_in     = count_ff;
      digits_in    = digits_ff;
      if (accept) begin
         mag_in       = raw[srde_pkg::VALUE_W-1] ? (~raw + srde_pkg::VALUE_W'(1)) : raw;
         sign_pend_in = raw[srde_pkg::VALUE_W-1];
      end
      // cleared again if the check fails
      if (state_ff == srde_pkg::ST_CHECK && !alphabet_ok) begin
         sign_pend_in = 1'b0;
      end
      if (out_load && sign_pend_ff) begin
         sign_pend_in = 1'b0;
      end
      // digit stack, top at entry 0
      if (push) begin
         count_in     = count_ff + srde_pkg::COUNT_W'(1);
         digits_in[0] = div_stat.digit;
         for (int k = 1; k < srde_pkg::MAX_DIGITS; k++) begin
            digits_in[k] = digits_ff[k-1];
         end
      end else if (pop) begin
         count_in = count_ff - srde_pkg::COUNT_W'(1);
         for (int k = 0; k < srde_pkg::MAX_DIGITS - 1; k++) begin
            digits_in[k] = digits_ff[k+1];
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_sym_in   = out_sym_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_sym_in   = sign_pend_ff ? srde_pkg::SIGN_MINUS : digit_sym;
         out_last_in  = !sign_pend_ff && (count_ff == srde_pkg::COUNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srde_pkg::ST_IDLE;
         sign_pend_ff <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sign_pend_ff <= sign_pend_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      digits_ff   <= digits_in;
      out_sym_ff  <= out_sym_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tlast  = out_last_ff;

   `SRDE_ASSERT(a_idle_empty,
      (state_ff == srde_pkg::ST_IDLE) |-> (count_ff == '0 && !sign_pend_ff),
      "idle with digits left")
   `SRDE_ASSERT(a_emit_nonempty,
      (state_ff == srde_pkg::ST_EMIT) |-> (count_ff != '0),
      "emit with empty stack")
   `SRDE_ASSERT(a_last_to_idle,
      (out_load && out_last_in) |=> (state_ff == srde_pkg::ST_IDLE),
      "final symbol without return to idle")
   `SRDE_ASSERT_ALWAYS(a_reset_clear,
      reset |=> (state_ff == srde_pkg::ST_IDLE && !rsp_tvalid),
      "reset did not clear sequencer")

endmodule
